// ===== rtl/core/prf_pkg.sv =====
`default_nettype none

package prf_pkg;

    // Default geometry
    localparam int NUM_QUEUES_DEF  = 5;
    localparam int QUEUE_BYTES_DEF = 1024;

    // Record header: length low, length high, flags
    localparam int HDR_BYTES = 3;

    // Field widths
    localparam int SEL_W  = 3;
    localparam int LEN_W  = 11;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int DROP_W = 32;

    // Request function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_PUSH_DROP = 2'd1;
    localparam logic [STAT_W-1:0] ST_POPPED    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // Kind of result beat to build
    localparam logic [1:0] EMIT_PUSH  = 2'd0;
    localparam logic [1:0] EMIT_EMPTY = 2'd1;
    localparam logic [1:0] EMIT_POP   = 2'd2;

    // Header byte capture selector
    localparam logic [1:0] CAP_NONE  = 2'd0;
    localparam logic [1:0] CAP_LO    = 2'd1;
    localparam logic [1:0] CAP_HI    = 2'd2;
    localparam logic [1:0] CAP_FLAGS = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       push_open;
        logic       push_data;
        logic       push_lo;
        logic       push_hi;
        logic       pop_start;
        logic       pop_next;
        logic       pop_arm;
        logic       pop_read;
        logic [1:0] cap;
        logic       emit;
        logic [1:0] kind;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic push_in_record;
        logic push_admitted;
        logic pop_in_record;
        logic item_last;
        logic found;
        logic len_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/priority_record_fifo.sv =====
// Priority record FIFO: NUM_QUEUES byte rings of QUEUE_BYTES each, holding whole records.
// Request channel (req_valid/req_stall): func 0 pushes one record byte into queue_sel,
// with record_len and record_flags taken at the record's first byte and last_byte closing
// it; func 1 pops one byte from the lowest-numbered queue holding a committed record.
// Response channel (rsp_valid/rsp_stall): one beat per request with status, popped byte,
// record length, flags, source queue, last marker and the running drop total.
// Steps, from request accept to response valid, all through one byte store:
//   push: a record's first byte adds an open step; the closing byte of an admitted
//   record adds the header length low and high rewrites.
//   pop: a record's first byte adds a queue scan and three header reads.
// One request is in flight at a time; req_stall is high until its beat is in the output
// register. A finished beat waits there while the next request is taken and worked on;
// a stalled receiver holds the beat and only blocks the following result.
// Reset clears all pointers, record state and the drop total; no clearing pass is run.
`default_nettype none

module priority_record_fifo #(
    parameter int NUM_QUEUES  = prf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_BYTES = prf_pkg::QUEUE_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          func,
    input  wire logic [prf_pkg::SEL_W-1:0]     queue_sel,
    input  wire logic [prf_pkg::LEN_W-1:0]     record_len,
    input  wire logic [prf_pkg::BYTE_W-1:0]    record_flags,
    input  wire logic [prf_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                          last_byte,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [prf_pkg::STAT_W-1:0]         status,
    output logic [prf_pkg::BYTE_W-1:0]         data_out,
    output logic [prf_pkg::LEN_W-1:0]          out_len,
    output logic [prf_pkg::BYTE_W-1:0]         out_flags,
    output logic [prf_pkg::SEL_W-1:0]          out_queue,
    output logic                               out_last,
    output logic [prf_pkg::DROP_W-1:0]         total_drops
);

    prf_pkg::cmd_t cmd;
    prf_pkg::sts_t sts;

    // Sequencer
    prf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store, pointers and result register
    prf_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_BYTES (QUEUE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .queue_sel    (queue_sel),
        .record_len   (record_len),
        .record_flags (record_flags),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cmd          (cmd),
        .sts          (sts),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .data_out     (data_out),
        .out_len      (out_len),
        .out_flags    (out_flags),
        .out_queue    (out_queue),
        .out_last     (out_last),
        .total_drops  (total_drops)
    );

endmodule

`default_nettype wire

// ===== rtl/core/prf_ctrl.sv =====
`default_nettype none

module prf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire logic          func,
    input  wire prf_pkg::sts_t sts,
    output prf_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PUSH_OPEN = 4'd1;
    localparam logic [3:0] S_PUSH_DATA = 4'd2;
    localparam logic [3:0] S_PUSH_LO   = 4'd3;
    localparam logic [3:0] S_PUSH_HI   = 4'd4;
    localparam logic [3:0] S_POP_SCAN  = 4'd5;
    localparam logic [3:0] S_POP_H1    = 4'd6;
    localparam logic [3:0] S_POP_H2    = 4'd7;
    localparam logic [3:0] S_POP_H3    = 4'd8;
    localparam logic [3:0] S_POP_RD    = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // State and result kind registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= prf_pkg::EMIT_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd           = '0;
        cmd.cap       = prf_pkg::CAP_NONE;
        cmd.kind      = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (func == prf_pkg::FUNC_POP)
                        state_next = sts.pop_in_record ? S_POP_RD : S_POP_SCAN;
                    else
                        state_next = sts.push_in_record ? S_PUSH_DATA : S_PUSH_OPEN;
                end
            end
            S_PUSH_OPEN:
            begin
                cmd.push_open = 1'b1;
                state_next    = S_PUSH_DATA;
            end
            S_PUSH_DATA:
            begin
                cmd.push_data = 1'b1;
                kind_next     = prf_pkg::EMIT_PUSH;
                if (sts.item_last && sts.push_admitted)
                    state_next = S_PUSH_LO;
                else
                    state_next = S_DONE;
            end
            S_PUSH_LO:
            begin
                cmd.push_lo = 1'b1;
                state_next  = S_PUSH_HI;
            end
            S_PUSH_HI:
            begin
                cmd.push_hi = 1'b1;
                state_next  = S_DONE;
            end
            S_POP_SCAN:
            begin
                if (sts.found)
                begin
                    cmd.pop_start = 1'b1;
                    state_next    = S_POP_H1;
                end
                else
                begin
                    kind_next  = prf_pkg::EMIT_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_POP_H1:
            begin
                cmd.cap      = prf_pkg::CAP_LO;
                cmd.pop_next = 1'b1;
                state_next   = S_POP_H2;
            end
            S_POP_H2:
            begin
                cmd.cap      = prf_pkg::CAP_HI;
                cmd.pop_next = 1'b1;
                state_next   = S_POP_H3;
            end
            S_POP_H3:
            begin
                cmd.cap = prf_pkg::CAP_FLAGS;
                if (sts.len_zero)
                begin
                    kind_next  = prf_pkg::EMIT_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.pop_arm = 1'b1;
                    state_next  = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_read = 1'b1;
                kind_next    = prf_pkg::EMIT_POP;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/prf_dp.sv =====
`default_nettype none

module prf_dp #(
    parameter int NUM_QUEUES  = prf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_BYTES = prf_pkg::QUEUE_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          func,
    input  wire logic [prf_pkg::SEL_W-1:0]     queue_sel,
    input  wire logic [prf_pkg::LEN_W-1:0]     record_len,
    input  wire logic [prf_pkg::BYTE_W-1:0]    record_flags,
    input  wire logic [prf_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                          last_byte,
    input  wire prf_pkg::cmd_t                 cmd,
    output prf_pkg::sts_t                      sts,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [prf_pkg::STAT_W-1:0]         status,
    output logic [prf_pkg::BYTE_W-1:0]         data_out,
    output logic [prf_pkg::LEN_W-1:0]          out_len,
    output logic [prf_pkg::BYTE_W-1:0]         out_flags,
    output logic [prf_pkg::SEL_W-1:0]          out_queue,
    output logic                               out_last,
    output logic [prf_pkg::DROP_W-1:0]         total_drops
);

    localparam int PW    = $clog2(QUEUE_BYTES);
    localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DEPTH = NUM_QUEUES * QUEUE_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = prf_pkg::LEN_W;
    localparam int BW    = prf_pkg::BYTE_W;
    localparam int CW    = ((PW + 1 > LW + 1) ? PW + 1 : LW + 1) + 1;

    localparam logic [PW:0]             QB_X   = (PW + 1)'(QUEUE_BYTES);
    localparam logic [prf_pkg::SEL_W:0] NQ_X   = (prf_pkg::SEL_W + 1)'(NUM_QUEUES);
    localparam logic [CW-1:0]           ROOM_X = CW'(QUEUE_BYTES - 1);
    localparam logic [CW-1:0]           HDR_X  = CW'(prf_pkg::HDR_BYTES);

    // Ring pointer advance by a small step
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [1:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(n);
        if (s >= QB_X)
            s = s - QB_X;
        return s[PW-1:0];
    endfunction

    // Flat store address of a queue slot
    function automatic logic [AW-1:0] mem_addr(input logic [QIW-1:0] q,
                                               input logic [PW-1:0] p);
        return AW'(int'(q) * QUEUE_BYTES + int'(p));
    endfunction

    // Byte store
    logic [BW-1:0] store_mem [DEPTH];
    logic [BW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Per-queue pointers
    logic [PW-1:0] wp_reg [NUM_QUEUES];
    logic [PW-1:0] cp_reg [NUM_QUEUES];
    logic [PW-1:0] rp_reg [NUM_QUEUES];
    logic [prf_pkg::DROP_W-1:0] total_reg;

    // Latched request beat
    logic                       item_func_reg;
    logic [prf_pkg::SEL_W-1:0]  item_sel_reg;
    logic [LW-1:0]              item_len_reg;
    logic [BW-1:0]              item_flags_reg;
    logic [BW-1:0]              item_data_reg;
    logic                       item_last_reg;

    // Push record state
    logic           push_in_record_reg;
    logic           push_admitted_reg;
    logic [QIW-1:0] push_q_reg;
    logic [LW-1:0]  push_len_reg;
    logic [LW-1:0]  count_reg;

    // Pop record state
    logic           pop_in_record_reg;
    logic [QIW-1:0] pop_q_reg;
    logic [LW-1:0]  pop_remaining_reg;
    logic [LW-1:0]  pop_length_reg;
    logic [BW-1:0]  pop_flags_reg;
    logic [LW-1:0]  remaining_next;

    // Output register
    logic                       rsp_valid_reg;
    logic [prf_pkg::STAT_W-1:0] status_reg;
    logic [BW-1:0]              data_out_reg;
    logic [LW-1:0]              out_len_reg;
    logic [BW-1:0]              out_flags_reg;
    logic [prf_pkg::SEL_W-1:0]  out_queue_reg;
    logic                       out_last_reg;
    logic [prf_pkg::DROP_W-1:0] total_drops_reg;

    logic           sel_ok;
    logic [QIW-1:0] sel_q;
    logic [PW-1:0]  wp_sel;
    logic [PW-1:0]  rp_sel;
    logic [PW:0]    used;
    logic [CW-1:0]  space;
    logic [CW-1:0]  need;
    logic           admit_ok;
    logic           drop_hit;
    logic           data_wr;
    logic           found;
    logic [QIW-1:0] found_q;
    logic           out_free;

    // Admission check at the first beat of a record
    always_comb
    begin
        sel_ok   = ({1'b0, item_sel_reg} < NQ_X);
        sel_q    = item_sel_reg[QIW-1:0];
        wp_sel   = wp_reg[sel_q];
        rp_sel   = rp_reg[sel_q];
        used     = {1'b0, wp_sel} - {1'b0, rp_sel} + ((wp_sel < rp_sel) ? QB_X : '0);
        space    = ROOM_X - CW'(used);
        need     = CW'(item_len_reg) + HDR_X;
        admit_ok = sel_ok && (item_len_reg != '0) && (space >= need);
        drop_hit = sel_ok && (item_len_reg != '0) && (space < need);
    end

    // A data beat is stored only inside the admitted length
    assign data_wr = cmd.push_data && push_admitted_reg && (count_reg < push_len_reg);

    // Lowest-numbered queue holding a committed record
    always_comb
    begin
        found   = 1'b0;
        found_q = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--)
        begin
            if (cp_reg[q] != rp_reg[q])
            begin
                found   = 1'b1;
                found_q = QIW'(q);
            end
        end
    end

    // Store write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (cmd.push_open && admit_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = mem_addr(sel_q, adv(wp_sel, 2'd2));
            mem_wdata = item_flags_reg;
        end
        else if (data_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = mem_addr(push_q_reg, wp_reg[push_q_reg]);
            mem_wdata = item_data_reg;
        end
        else if (cmd.push_lo)
        begin
            mem_we    = 1'b1;
            mem_waddr = mem_addr(push_q_reg, cp_reg[push_q_reg]);
            mem_wdata = count_reg[BW-1:0];
        end
        else if (cmd.push_hi)
        begin
            mem_we    = 1'b1;
            mem_waddr = mem_addr(push_q_reg, adv(cp_reg[push_q_reg], 2'd1));
            mem_wdata = BW'(count_reg[LW-1:BW]);
        end
    end

    // Store read port
    always_comb
    begin
        mem_re    = cmd.pop_start || cmd.pop_next || cmd.pop_read;
        mem_raddr = cmd.pop_start ? mem_addr(found_q, rp_reg[found_q])
                                  : mem_addr(pop_q_reg, rp_reg[pop_q_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= store_mem[mem_raddr];
    end

    // Request beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_func_reg  <= func;
            item_sel_reg   <= queue_sel;
            item_len_reg   <= record_len;
            item_flags_reg <= record_flags;
            item_data_reg  <= data_byte;
            item_last_reg  <= last_byte;
        end
    end

    // Pointers, drop total and push record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                wp_reg[q] <= '0;
                cp_reg[q] <= '0;
                rp_reg[q] <= '0;
            end
            total_reg          <= '0;
            push_in_record_reg <= 1'b0;
            push_admitted_reg  <= 1'b0;
            push_q_reg         <= '0;
            push_len_reg       <= '0;
            count_reg          <= '0;
        end
        else
        begin
            if (cmd.push_open)
            begin
                push_in_record_reg <= 1'b1;
                push_admitted_reg  <= admit_ok;
                push_q_reg         <= sel_q;
                push_len_reg       <= item_len_reg;
                count_reg          <= '0;
                if (admit_ok)
                    wp_reg[sel_q] <= adv(wp_sel, 2'd3);
                if (drop_hit)
                    total_reg <= total_reg + 1'b1;
            end
            if (data_wr)
            begin
                wp_reg[push_q_reg] <= adv(wp_reg[push_q_reg], 2'd1);
                count_reg          <= count_reg + 1'b1;
            end
            if (cmd.push_hi)
                cp_reg[push_q_reg] <= wp_reg[push_q_reg];
            if (cmd.pop_start)
                rp_reg[found_q] <= adv(rp_reg[found_q], 2'd1);
            if (cmd.pop_next || cmd.pop_read)
                rp_reg[pop_q_reg] <= adv(rp_reg[pop_q_reg], 2'd1);
            // Record closes once its last beat has been answered
            if (cmd.emit && (item_func_reg == prf_pkg::FUNC_PUSH) && item_last_reg)
            begin
                push_in_record_reg <= 1'b0;
                push_admitted_reg  <= 1'b0;
            end
        end
    end

    assign remaining_next = pop_remaining_reg - 1'b1;

    // Pop record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_in_record_reg <= 1'b0;
            pop_q_reg         <= '0;
            pop_remaining_reg <= '0;
            pop_length_reg    <= '0;
            pop_flags_reg     <= '0;
        end
        else
        begin
            if (cmd.pop_start)
                pop_q_reg <= found_q;
            case (cmd.cap)
                prf_pkg::CAP_LO:    pop_length_reg[BW-1:0]  <= rdata_reg;
                prf_pkg::CAP_HI:    pop_length_reg[LW-1:BW] <= rdata_reg[LW-BW-1:0];
                prf_pkg::CAP_FLAGS: pop_flags_reg           <= rdata_reg;
                default:            ;
            endcase
            if (cmd.pop_arm)
            begin
                pop_in_record_reg <= 1'b1;
                pop_remaining_reg <= pop_length_reg;
            end
            if (cmd.pop_read)
            begin
                pop_remaining_reg <= remaining_next;
                pop_in_record_reg <= (remaining_next != '0);
            end
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            total_drops_reg <= total_reg;
            status_reg      <= prf_pkg::ST_EMPTY;
            data_out_reg    <= '0;
            out_len_reg     <= '0;
            out_flags_reg   <= '0;
            out_queue_reg   <= '0;
            out_last_reg    <= 1'b0;
            case (cmd.kind)
                prf_pkg::EMIT_PUSH:
                begin
                    status_reg <= push_admitted_reg ? prf_pkg::ST_PUSH_OK
                                                    : prf_pkg::ST_PUSH_DROP;
                end
                prf_pkg::EMIT_POP:
                begin
                    status_reg    <= prf_pkg::ST_POPPED;
                    data_out_reg  <= rdata_reg;
                    out_len_reg   <= pop_length_reg;
                    out_flags_reg <= pop_flags_reg;
                    out_queue_reg <= prf_pkg::SEL_W'(pop_q_reg);
                    out_last_reg  <= (pop_remaining_reg == '0);
                end
                default:
                begin
                    status_reg <= prf_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.push_in_record = push_in_record_reg;
        sts.push_admitted  = push_admitted_reg;
        sts.pop_in_record  = pop_in_record_reg;
        sts.item_last      = item_last_reg;
        sts.found          = found;
        sts.len_zero       = (pop_length_reg == '0);
        sts.out_free       = out_free;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign out_len     = out_len_reg;
    assign out_flags   = out_flags_reg;
    assign out_queue   = out_queue_reg;
    assign out_last    = out_last_reg;
    assign total_drops = total_drops_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import prf_pkg::*;

    localparam int NQ           = NUM_QUEUES_DEF;
    localparam int QB           = QUEUE_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 30;

    // One request beat as the sender presents it
    typedef struct {
        logic              func;
        logic [SEL_W-1:0]  sel;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] data;
        logic              last;
        bit                hold_drain;   // wait for all responses before this beat
    } req_t;

    // One response beat
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] flags;
        logic [SEL_W-1:0]  queue;
        logic              last;
        logic [DROP_W-1:0] drops;
    } answer_t;

    typedef enum int { RX_FREE, RX_RANDOM, RX_BURSTY, RX_TOGGLE } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic              req_stall;
    logic              func = FUNC_PUSH;
    logic [SEL_W-1:0]  queue_sel = '0;
    logic [LEN_W-1:0]  record_len = '0;
    logic [BYTE_W-1:0] record_flags = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              last_byte = 1'b0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data_out;
    logic [LEN_W-1:0]  out_len;
    logic [BYTE_W-1:0] out_flags;
    logic [SEL_W-1:0]  out_queue;
    logic              out_last;
    logic [DROP_W-1:0] total_drops;

    priority_record_fifo #(
        .NUM_QUEUES  (NQ),
        .QUEUE_BYTES (QB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .queue_sel    (queue_sel),
        .record_len   (record_len),
        .record_flags (record_flags),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .data_out     (data_out),
        .out_len      (out_len),
        .out_flags    (out_flags),
        .out_queue    (out_queue),
        .out_last     (out_last),
        .total_drops  (total_drops)
    );

    // Request beats waiting to go out, and responses owed by the block
    req_t    request_q [$];
    answer_t answers_due [$];

    int      errors = 0;
    int      req_taken = 0;
    int      rsp_matched = 0;
    int      cycle_cnt = 0;

    // Shadow state of the ring queues
    bit [7:0]        ring [NQ][QB];
    int unsigned     wr_ptr [NQ];
    int unsigned     cm_ptr [NQ];
    int unsigned     rd_ptr [NQ];
    bit [DROP_W-1:0] drop_cnt [NQ];
    bit              in_push;
    bit              push_kept;
    int unsigned     push_q;
    bit [LEN_W-1:0]  push_len;
    bit [LEN_W-1:0]  push_cnt;
    bit              in_pop;
    int unsigned     pop_src;
    bit [LEN_W-1:0]  pop_left;
    bit [LEN_W-1:0]  pop_len;
    bit [BYTE_W-1:0] pop_flg;

    function automatic int unsigned ring_dist(int unsigned from, int unsigned to);
        return (to + QB - from) % QB;
    endfunction

    function automatic void put_ring(int unsigned q, logic [7:0] v);
        ring[q][wr_ptr[q]] = v;
        wr_ptr[q] = (wr_ptr[q] + 1) % QB;
    endfunction

    // Advance the shadow queues by one request and build the response it earns
    function automatic answer_t answer_request(req_t r);
        answer_t         a;
        bit [DROP_W-1:0] sum;
        int unsigned     used;
        int unsigned     space;
        int unsigned     q;
        bit              found;
        bit [7:0]        lo;
        bit [7:0]        hi;
        a = '{default: '0};
        q = 0;
        if (r.func == FUNC_PUSH)
        begin
            // first byte: admission check against free space
            if (!in_push)
            begin
                in_push = 1'b1;
                push_kept = 1'b0;
                if (r.sel < NQ && r.len != 0)
                begin
                    used = ring_dist(rd_ptr[r.sel], wr_ptr[r.sel]);
                    space = QB - 1 - used;
                    if (space < r.len + HDR_BYTES)
                        drop_cnt[r.sel] = drop_cnt[r.sel] + 1;
                    else
                    begin
                        push_q = 32'(r.sel);
                        push_len = r.len;
                        push_cnt = '0;
                        put_ring(push_q, r.len[7:0]);
                        put_ring(push_q, {5'b0, r.len[10:8]});
                        put_ring(push_q, r.flags);
                        push_kept = 1'b1;
                    end
                end
            end
            a.status = push_kept ? ST_PUSH_OK : ST_PUSH_DROP;
            if (push_kept)
            begin
                // bytes past the header length are thrown away
                if (push_cnt < push_len)
                begin
                    put_ring(push_q, r.data);
                    push_cnt++;
                end
                // commit, with the length patched to what was stored
                if (r.last)
                begin
                    ring[push_q][cm_ptr[push_q]] = push_cnt[7:0];
                    ring[push_q][(cm_ptr[push_q] + 1) % QB] = {5'b0, push_cnt[10:8]};
                    cm_ptr[push_q] = wr_ptr[push_q];
                end
            end
            if (r.last)
            begin
                in_push = 1'b0;
                push_kept = 1'b0;
            end
        end
        else
        begin
            a.status = ST_EMPTY;
            // pick the highest-priority committed record and read its header
            if (!in_pop)
            begin
                found = 1'b0;
                for (int i = 0; i < NQ; i++)
                begin
                    if (!found && cm_ptr[i] != rd_ptr[i])
                    begin
                        found = 1'b1;
                        q = i;
                    end
                end
                if (found)
                begin
                    lo = ring[q][rd_ptr[q]];
                    hi = ring[q][(rd_ptr[q] + 1) % QB];
                    pop_flg = ring[q][(rd_ptr[q] + 2) % QB];
                    rd_ptr[q] = (rd_ptr[q] + HDR_BYTES) % QB;
                    pop_len = {hi[2:0], lo};
                    pop_left = pop_len;
                    pop_src = q;
                    in_pop = (pop_len != 0);
                end
            end
            if (in_pop)
            begin
                a.data = ring[pop_src][rd_ptr[pop_src]];
                rd_ptr[pop_src] = (rd_ptr[pop_src] + 1) % QB;
                pop_left = pop_left - 1'b1;
                a.last = (pop_left == 0);
                in_pop = (pop_left != 0);
                a.status = ST_POPPED;
                a.len = pop_len;
                a.flags = pop_flg;
                a.queue = SEL_W'(pop_src);
            end
        end
        sum = '0;
        for (int i = 0; i < NQ; i++)
            sum = sum + drop_cnt[i];
        a.drops = sum;
        return a;
    endfunction

    function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Stimulus builders
    task automatic queue_byte(logic [SEL_W-1:0] sel, logic [LEN_W-1:0] len,
                              logic [BYTE_W-1:0] flags, logic last);
        req_t r;
        r.func = FUNC_PUSH;
        r.sel = sel;
        r.len = len;
        r.flags = flags;
        r.data = BYTE_W'($urandom);
        r.last = last;
        r.hold_drain = 1'b0;
        request_q.push_back(r);
    endtask

    task automatic queue_pop(bit hold);
        req_t r;
        r.func = FUNC_POP;
        r.sel = SEL_W'($urandom);
        r.len = LEN_W'($urandom);
        r.flags = BYTE_W'($urandom);
        r.data = BYTE_W'($urandom);
        r.last = 1'($urandom);
        r.hold_drain = hold;
        request_q.push_back(r);
    endtask

    // A whole record; only its first byte carries meaningful header fields
    task automatic queue_record(logic [SEL_W-1:0] sel, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] flags, int nbytes, int unsigned mix);
        queue_byte(sel, len, flags, nbytes == 1);
        for (int i = 1; i < nbytes; i++)
        begin
            if ($urandom_range(0, 99) < mix)
                queue_pop(1'b0);
            queue_byte(SEL_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom),
                       i == nbytes - 1);
        end
    endtask

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: bursts of beats with random gaps between them
    req_t    on_bus;
    answer_t next_answer;
    int      gap_left = 0;
    int      burst_left = 0;
    bit      fire;
    bit      launch;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            fire = req_valid && !req_stall;
            if (fire)
            begin
                next_answer = answer_request(on_bus);
                answers_due.push_back(next_answer);
                req_taken <= req_taken + 1;
            end
            if (fire || !req_valid)
            begin
                launch = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() > 0 &&
                         (!request_q[0].hold_drain || (!fire && req_taken == rsp_matched)))
                begin
                    on_bus = request_q.pop_front();
                    launch = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                req_valid <= launch;
                if (launch)
                begin
                    func <= on_bus.func;
                    queue_sel <= on_bus.sel;
                    record_len <= on_bus.len;
                    record_flags <= on_bus.flags;
                    data_byte <= on_bus.data;
                    last_byte <= on_bus.last;
                end
            end
        end
    end

    // Monitor: compare each response beat, and drive the receiver stall pattern
    answer_t  owed;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_span = 0;
    int       rx_run = 0;
    bit       rx_hold = 1'b0;
    bit       stall_next;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("response beat with no request waiting for it");
                errors++;
            end
            else
            begin
                owed = answers_due.pop_front();
                errors += check_field("status", 32'(owed.status), 32'(status))
                        + check_field("data_out", 32'(owed.data), 32'(data_out))
                        + check_field("out_len", 32'(owed.len), 32'(out_len))
                        + check_field("out_flags", 32'(owed.flags), 32'(out_flags))
                        + check_field("out_queue", 32'(owed.queue), 32'(out_queue))
                        + check_field("out_last", 32'(owed.last), 32'(out_last))
                        + check_field("total_drops", owed.drops, total_drops);
                rsp_matched <= rsp_matched + 1;
            end
        end

        // pick a new stall style now and then
        if (rx_span == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_span = $urandom_range(40, 200);
        end
        else
            rx_span--;
        case (rx_mode)
            RX_FREE:   stall_next = 1'b0;
            RX_RANDOM: stall_next = ($urandom_range(0, 99) < 35);
            RX_BURSTY:
            begin
                if (rx_run == 0)
                begin
                    rx_hold = !rx_hold;
                    rx_run = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 5);
                end
                else
                    rx_run--;
                stall_next = rx_hold;
            end
            default:   stall_next = !rsp_stall;
        endcase
        rsp_stall <= stall_next;
    end

    // Stimulus, reset and end of run
    int unsigned pop_mix [4] = '{5, 25, 50, 85};
    int unsigned pop_pct;
    int          span;
    int          pick;
    int          nbytes;
    int          rand_end;
    logic [SEL_W-1:0] sel;
    logic [LEN_W-1:0] len;

    initial
    begin
        // directed: empty pop, minimum length, excess byte
        queue_pop(1'b0);
        queue_byte(3'd0, 11'd1, 8'hFF, 1'b1);
        queue_record(3'd4, 11'd2, 8'h00, 3, 0);
        // pops while a record on queue 1 is still open
        queue_byte(3'd1, 11'd5, 8'hA5, 1'b0);
        queue_pop(1'b0);
        queue_pop(1'b0);
        for (int i = 0; i < 4; i++)
            queue_byte(SEL_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom), i == 3);
        // queue 1 holds 8 bytes: exact fit admitted and cut short, then one too many
        queue_byte(3'd1, 11'd1012, 8'h5A, 1'b1);
        queue_byte(3'd1, 11'd1009, 8'h96, 1'b1);
        // never fits, one past fit in an empty queue
        queue_record(3'd2, 11'd2047, 8'hC3, 2, 0);
        queue_byte(3'd3, 11'd1021, 8'h3C, 1'b1);
        // bad queue selects and zero length
        queue_record(3'd7, 11'd3, 8'h81, 2, 0);
        queue_byte(3'd5, 11'd1, 8'h7E, 1'b1);
        queue_byte(3'd0, 11'd0, 8'h18, 1'b1);
        // drain everything once all earlier responses are back
        queue_pop(1'b1);
        for (int i = 0; i < 7; i++)
            queue_pop(1'b0);

        // random: episodes of differing push/pop balance
        rand_end = request_q.size() + RANDOM_ITEMS;
        while (request_q.size() < rand_end)
        begin
            pop_pct = pop_mix[$urandom_range(0, 3)];
            span = $urandom_range(20, 90);
            for (int k = 0; k < span && request_q.size() < rand_end; k++)
            begin
                if ($urandom_range(0, 99) < pop_pct)
                    queue_pop($urandom_range(0, 199) == 0);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        sel = '0;
                    else if (pick < 95)
                        sel = SEL_W'($urandom_range(1, NQ - 1));
                    else
                        sel = SEL_W'($urandom_range(NQ, 7));
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        len = LEN_W'($urandom_range(1, 3));
                    else if (pick < 85)
                        len = LEN_W'($urandom_range(4, 16));
                    else if (pick < 97)
                        len = LEN_W'($urandom_range(17, 80));
                    else
                        len = LEN_W'($urandom_range(0, 2047));
                    // long or empty headers get a few bytes only
                    if (len == 0 || len > 80)
                        nbytes = $urandom_range(1, 3);
                    else
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick == 0)
                            nbytes = $urandom_range(1, 32'(len));
                        else if (pick == 1)
                            nbytes = 32'(len) + $urandom_range(1, 3);
                        else
                            nbytes = 32'(len);
                    end
                    queue_record(sel, len, BYTE_W'($urandom), nbytes, pop_pct / 4);
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid || req_taken != rsp_matched)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (answers_due.size() != 0)
        begin
            $error("%0d response beats never arrived", answers_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/prf_pkg.sv
rtl/core/prf_ctrl.sv
rtl/core/prf_dp.sv
rtl/core/priority_record_fifo.sv
sim/tb.sv
